// File: rtl/dcsg_pkg.sv
// Shared types and constants for the drive command safety gateway.
package dcsg_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int DIST_W     = 10;
    localparam int BYTE_W     = 8;
    localparam int CODE_W     = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_DIST = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIST   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HB_LIMIT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TELE_PER   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_PER  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIM  = 3'd5;

    localparam logic [DIST_W-1:0] RST_BRAKE_DIST = 10'd15;
    localparam logic [DIST_W-1:0] RST_MIN_DIST   = 10'd3;
    localparam logic [BYTE_W-1:0] RST_HB_LIMIT   = 8'd50;
    localparam logic [BYTE_W-1:0] RST_TELE_PER   = 8'd6;
    localparam logic [BYTE_W-1:0] RST_BLINK_PER  = 8'd20;
    localparam logic [BYTE_W-1:0] RST_SPEED_LIM  = 8'd100;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [CODE_W-1:0] CODE_STOP    = 3'd0;
    localparam logic [CODE_W-1:0] CODE_FORWARD = 3'd1;
    localparam logic [CODE_W-1:0] CODE_BEEP    = 3'd5;

    localparam logic STAGE_CODE  = 1'b0;
    localparam logic STAGE_SPEED = 1'b1;

    typedef struct packed {
        logic [DIST_W-1:0] brake_distance;
        logic [DIST_W-1:0] min_valid_distance;
        logic [BYTE_W-1:0] heartbeat_limit;
        logic [BYTE_W-1:0] telemetry_period;
        logic [BYTE_W-1:0] blink_period;
        logic [BYTE_W-1:0] speed_limit;
    } cfg_t;

    typedef struct packed {
        logic              command;
        logic [BYTE_W-1:0] rx_byte;
        logic [DIST_W-1:0] front_distance;
    } item_t;

    typedef struct packed {
        logic [CODE_W-1:0] drive_cmd;
        logic [BYTE_W-1:0] drive_speed;
        logic              drive_update;
        logic              buzzer;
        logic              beep_request;
        logic              telemetry_due;
        logic              link_lost;
        logic              brake_active;
    } result_t;

endpackage

// File: rtl/dcsg_cfg.sv
// Configuration register file of the drive command safety gateway.
module dcsg_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write_en,
    input  logic [dcsg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dcsg_pkg::CFG_DATA_W-1:0]  cfg_data,
    output dcsg_pkg::cfg_t                   cfg
);
    import dcsg_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_BRAKE_DIST: cfg_next.brake_distance     = cfg_data;
                CFG_MIN_DIST:   cfg_next.min_valid_distance = cfg_data;
                CFG_HB_LIMIT:   cfg_next.heartbeat_limit    = cfg_data[BYTE_W-1:0];
                CFG_TELE_PER:   cfg_next.telemetry_period   = cfg_data[BYTE_W-1:0];
                CFG_BLINK_PER:  cfg_next.blink_period       = cfg_data[BYTE_W-1:0];
                CFG_SPEED_LIM:  cfg_next.speed_limit        = cfg_data[BYTE_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.brake_distance     <= RST_BRAKE_DIST;
            cfg_reg.min_valid_distance <= RST_MIN_DIST;
            cfg_reg.heartbeat_limit    <= RST_HB_LIMIT;
            cfg_reg.telemetry_period   <= RST_TELE_PER;
            cfg_reg.blink_period       <= RST_BLINK_PER;
            cfg_reg.speed_limit        <= RST_SPEED_LIM;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/dcsg_core.sv
// Gateway state registers and the per-item parse, timer and safety logic.
module dcsg_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  dcsg_pkg::item_t   item,
    input  dcsg_pkg::cfg_t    cfg,
    output dcsg_pkg::result_t result
);
    import dcsg_pkg::*;

    logic              stage_reg,   stage_next;
    logic [CODE_W-1:0] held_reg,    held_next;
    logic [BYTE_W-1:0] silence_reg, silence_next;
    logic              lost_reg,    lost_next;
    logic [BYTE_W-1:0] period_reg,  period_next;
    logic [BYTE_W-1:0] blink_reg,   blink_next;
    logic              buzz_reg,    buzz_next;
    logic [CODE_W-1:0] code_reg,    code_next;
    logic [BYTE_W-1:0] rate_reg,    rate_next;

    logic              packet;
    logic [CODE_W-1:0] pk_code;
    logic [BYTE_W-1:0] pk_rate;
    logic [BYTE_W-1:0] period_inc;
    logic [BYTE_W-1:0] blink_inc;
    logic              tele;
    logic              upd;
    logic              brk;
    logic              beep;
    logic              in_window;

    assign in_window = (item.front_distance >= cfg.min_valid_distance) &&
                       (item.front_distance < cfg.brake_distance);
    assign period_inc = period_reg + 8'd1;
    assign blink_inc  = blink_reg + 8'd1;

    always_comb
    begin
        stage_next   = stage_reg;
        held_next    = held_reg;
        silence_next = silence_reg;
        lost_next    = lost_reg;
        period_next  = period_reg;
        blink_next   = blink_reg;
        buzz_next    = buzz_reg;
        code_next    = code_reg;
        rate_next    = rate_reg;
        packet       = 1'b0;
        pk_code      = held_reg;
        pk_rate      = (item.rx_byte > cfg.speed_limit) ? cfg.speed_limit : item.rx_byte;
        tele         = 1'b0;
        upd          = 1'b0;
        brk          = 1'b0;
        beep         = 1'b0;

        if (item.command == CMD_BYTE)
        begin
            // Any byte restores the link; the parser restarts on a restore.
            silence_next = '0;
            lost_next    = 1'b0;
            if (lost_reg || stage_reg == STAGE_CODE)
            begin
                if (item.rx_byte <= {{(BYTE_W-CODE_W){1'b0}}, CODE_BEEP})
                begin
                    held_next  = item.rx_byte[CODE_W-1:0];
                    stage_next = STAGE_SPEED;
                end
                else
                begin
                    stage_next = STAGE_CODE;
                end
            end
            else
            begin
                packet     = 1'b1;
                stage_next = STAGE_CODE;
            end
        end
        else
        begin
            if (period_inc >= cfg.telemetry_period)
            begin
                period_next = '0;
                tele        = 1'b1;
            end
            else
            begin
                period_next = period_inc;
            end
            if (silence_reg < cfg.heartbeat_limit)
            begin
                silence_next = silence_reg + 8'd1;
            end
            else if (!lost_reg)
            begin
                lost_next  = 1'b1;
                stage_next = STAGE_CODE;
            end
            if (lost_next)
            begin
                if (blink_inc >= cfg.blink_period)
                begin
                    blink_next = '0;
                    buzz_next  = ~buzz_reg;
                end
                else
                begin
                    blink_next = blink_inc;
                end
            end
            else
            begin
                blink_next = '0;
            end
        end

        // First safety check on the state left by the event.
        if (lost_next)
        begin
            code_next = CODE_STOP;
            rate_next = '0;
            upd       = 1'b1;
        end
        else if (code_reg == CODE_FORWARD && in_window)
        begin
            code_next = CODE_STOP;
            rate_next = '0;
            buzz_next = 1'b1;
            upd       = 1'b1;
            brk       = 1'b1;
        end
        else
        begin
            buzz_next = 1'b0;
            if (packet)
            begin
                if (pk_code == CODE_BEEP)
                begin
                    beep = 1'b1;
                end
                else if (pk_code != code_reg || pk_rate != rate_reg)
                begin
                    code_next = pk_code;
                    rate_next = pk_rate;
                    upd       = 1'b1;
                end
                // Second check: a new forward command may land inside the window.
                if (code_next == CODE_FORWARD && in_window)
                begin
                    code_next = CODE_STOP;
                    rate_next = '0;
                    buzz_next = 1'b1;
                    upd       = 1'b1;
                    brk       = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg   <= STAGE_CODE;
            held_reg    <= '0;
            silence_reg <= '0;
            lost_reg    <= 1'b0;
            period_reg  <= '0;
            blink_reg   <= '0;
            buzz_reg    <= 1'b0;
            code_reg    <= CODE_STOP;
            rate_reg    <= '0;
        end
        else if (advance)
        begin
            stage_reg   <= stage_next;
            held_reg    <= held_next;
            silence_reg <= silence_next;
            lost_reg    <= lost_next;
            period_reg  <= period_next;
            blink_reg   <= blink_next;
            buzz_reg    <= buzz_next;
            code_reg    <= code_next;
            rate_reg    <= rate_next;
        end
    end

    always_comb
    begin
        result.drive_cmd     = code_next;
        result.drive_speed   = rate_next;
        result.drive_update  = upd;
        result.buzzer        = buzz_next;
        result.beep_request  = beep;
        result.telemetry_due = tele;
        result.link_lost     = lost_next;
        result.brake_active  = brk;
    end

endmodule

// File: rtl/drive_command_safety_gateway.sv
// Top level of the drive command safety gateway: item, result and config ports.
// Usage:
//   Input channel (in_valid/in_ready) carries one item per handshake: a link
//   byte (command 0) or a timer tick (command 1), plus the front distance.
//   Output channel (out_valid/out_ready) returns exactly one result per item:
//   drive code and speed, motor reissue flag, buzzer level, beep, telemetry,
//   link-lost and emergency-brake flags.
//   Configuration is a plain write port (cfg_write_en, cfg_index, cfg_data);
//   write only while no item is in flight.
// Timing:
//   An accepted item lands in the input register; its core result is
//   registered in the result register once that is free, raising out_valid.
//   Throughput: one item per cycle while out_ready stays high; the input
//   register moves whenever the result register is free.
// Reset:
//   Both registers empty, parser awaiting a command byte, drive stopped,
//   buzzer off, all counters zero, configuration at its default values.
// Stall:
//   When out_ready is low the result holds, the input register holds one
//   more item, and in_ready drops until the result is taken.
module drive_command_safety_gateway (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             command,
    input  logic [7:0]                       rx_byte,
    input  logic [9:0]                       front_distance,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [2:0]                       drive_cmd,
    output logic [7:0]                       drive_speed,
    output logic                             drive_update,
    output logic                             buzzer,
    output logic                             beep_request,
    output logic                             telemetry_due,
    output logic                             link_lost,
    output logic                             brake_active,
    input  logic                             cfg_write_en,
    input  logic [dcsg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dcsg_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import dcsg_pkg::*;

    cfg_t    cfg;
    item_t   item_reg;
    logic    item_valid_reg;
    result_t core_result;
    result_t result_reg;
    logic    result_valid_reg;
    logic    advance;

    // Move an item into the result register when that register is free.
    assign advance  = item_valid_reg && (!result_valid_reg || out_ready);
    assign in_ready = !item_valid_reg || advance;

    dcsg_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    dcsg_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (core_result)
    );

    // Hold the item and result flags; payloads need no reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                item_valid_reg <= in_valid;
            end
            if (advance)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg.command        <= command;
            item_reg.rx_byte        <= rx_byte;
            item_reg.front_distance <= front_distance;
        end
        if (advance)
        begin
            result_reg <= core_result;
        end
    end

    assign out_valid     = result_valid_reg;
    assign drive_cmd     = result_reg.drive_cmd;
    assign drive_speed   = result_reg.drive_speed;
    assign drive_update  = result_reg.drive_update;
    assign buzzer        = result_reg.buzzer;
    assign beep_request  = result_reg.beep_request;
    assign telemetry_due = result_reg.telemetry_due;
    assign link_lost     = result_reg.link_lost;
    assign brake_active  = result_reg.brake_active;

endmodule
